// ----- hw/rtl/usbao_pkg.sv -----
// Package: widths, descriptor codes and the result word type of the descriptor scanner.
`default_nettype none

package usbao_pkg;

  // Field widths.
  localparam int ByteW    = 8;
  localparam int PacketW  = 11;
  localparam int RateW    = 24;
  localparam int FlagW    = 3;

  // Bytes 1 to 10 of each descriptor are kept.
  localparam int CaptureDepth = 10;
  localparam int CaptureIdxW  = $clog2(CaptureDepth);

  // Descriptor type and class codes.
  localparam logic [ByteW-1:0] TypeIface      = 8'h04;
  localparam logic [ByteW-1:0] TypeEndpoint   = 8'h05;
  localparam logic [ByteW-1:0] TypeClassIface = 8'h24;
  localparam logic [ByteW-1:0] AudioClass     = 8'h01;
  localparam logic [ByteW-1:0] AsSubclass     = 8'h02;
  localparam logic [ByteW-1:0] SubGeneral     = 8'h01;
  localparam logic [ByteW-1:0] SubFormat      = 8'h02;
  localparam logic [ByteW-1:0] FmtTypeOne     = 8'h01;
  localparam logic [15:0]      TagPcm         = 16'h0001;
  localparam logic [1:0]       XferIso        = 2'b01;

  // Minimum descriptor lengths.
  localparam logic [ByteW-1:0] MinLength      = 8'd2;
  localparam logic [ByteW-1:0] IfaceMinLen    = 8'd9;
  localparam logic [ByteW-1:0] ClassMinLen    = 8'd3;
  localparam logic [ByteW-1:0] GeneralMinLen  = 8'd7;
  localparam logic [ByteW-1:0] FormatMinLen   = 8'd11;
  localparam logic [ByteW-1:0] EndpointMinLen = 8'd7;
  localparam logic [ByteW-1:0] LastCaptureOff = 8'd10;

  // Values required of a complete streaming setting.
  localparam logic [ByteW-1:0] WantSubframe = 8'd2;
  localparam logic [ByteW-1:0] WantBits     = 8'd16;

  // Group flag bit positions.
  localparam int FlagAs  = 0;
  localparam int FlagPcm = 1;
  localparam int FlagFmt = 2;

  // One result word.
  typedef struct packed {
    logic               found;
    logic [ByteW-1:0]   iface_number;
    logic [ByteW-1:0]   alt_setting;
    logic [ByteW-1:0]   endpoint_address;
    logic [PacketW-1:0] max_packet;
    logic [ByteW-1:0]   channel_count;
    logic [ByteW-1:0]   subframe_bytes;
    logic [ByteW-1:0]   resolution_bits;
    logic [RateW-1:0]   sample_rate;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/usbao_if.sv -----
// Interfaces: the descriptor byte channel and the result channel of the scanner.
`default_nettype none

interface usbao_byte_if import usbao_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             end_of_set;

  modport source (output valid, output data_byte, output end_of_set, input ready);
  modport sink   (input valid, input data_byte, input end_of_set, output ready);
endinterface

interface usbao_result_if import usbao_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [ByteW-1:0]   iface_number;
  logic [ByteW-1:0]   alt_setting;
  logic [ByteW-1:0]   endpoint_address;
  logic [PacketW-1:0] max_packet;
  logic [ByteW-1:0]   channel_count;
  logic [ByteW-1:0]   subframe_bytes;
  logic [ByteW-1:0]   resolution_bits;
  logic [RateW-1:0]   sample_rate;

  modport source (output valid, output found, output iface_number, output alt_setting,
                  output endpoint_address, output max_packet, output channel_count,
                  output subframe_bytes, output resolution_bits, output sample_rate,
                  input ready);
  modport sink   (input valid, input found, input iface_number, input alt_setting,
                  input endpoint_address, input max_packet, input channel_count,
                  input subframe_bytes, input resolution_bits, input sample_rate,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/usb_audio_out_descriptor_scanner.sv -----
// Top level: USB audio OUT streaming-setting scanner over a configuration descriptor set.
//
//   Channel   Dir  Word                      Accepted when
//   bytes     in   data_byte, end_of_set     bytes.valid && bytes.ready
//   result    out  found and setting fields  result.valid && result.ready
//
// One byte is taken per cycle while bytes.ready is high; each byte is handled by
// the state update in the same cycle it is accepted. The word with end_of_set set
// registers one result word in the output register, or in the skid register behind
// it while the output register holds a word not taken. Bytes keep flowing while a
// result waits; bytes.ready drops only when both hold one. Reset (rst, synchronous)
// clears scan state and both output stages; each set's end also resets scan state.
`default_nettype none

module usb_audio_out_descriptor_scanner import usbao_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  usbao_byte_if.sink     bytes,
  usbao_result_if.source result
);

  // Current group of interface, class and endpoint settings.
  typedef struct packed {
    logic [ByteW-1:0]   iface;
    logic [ByteW-1:0]   alt;
    logic [FlagW-1:0]   flags;
    logic [ByteW-1:0]   channels;
    logic [ByteW-1:0]   subframe;
    logic [ByteW-1:0]   bits;
    logic [RateW-1:0]   rate;
    logic [ByteW-1:0]   endpoint;
    logic [PacketW-1:0] packet;
  } group_t;

  function automatic logic setting_ok(input group_t g);
    setting_ok = (g.flags == {FlagW{1'b1}}) && (g.alt != '0) && (g.channels != '0) &&
                 (g.subframe == WantSubframe) && (g.bits == WantBits) &&
                 (g.rate != '0) && (g.endpoint != '0);
  endfunction

  // Scan state.
  logic [ByteW-1:0] byte_offset, byte_offset_next;
  logic [ByteW-1:0] descriptor_length, descriptor_length_next;
  logic             scan_stopped, scan_stopped_next;
  group_t           group, group_next;
  logic [ByteW-1:0] capture_bytes [CaptureDepth];
  logic [ByteW-1:0] view [CaptureDepth];

  // Output register and skid register.
  result_t out_word, skid_word, res_word;
  logic    out_valid, skid_valid;

  logic                   in_fire, out_fire, res_fire;
  logic                   cap_we, finish, in_as, iface_stop;
  logic [CaptureIdxW-1:0] cap_idx;
  logic [ByteW-1:0]       off_inc;

  assign in_fire     = bytes.valid && bytes.ready;
  assign out_fire    = result.valid && result.ready;
  assign res_fire    = in_fire && bytes.end_of_set;
  assign bytes.ready = !skid_valid;

  // Byte position tracking and capture write.
  always_comb begin
    byte_offset_next       = byte_offset;
    descriptor_length_next = descriptor_length;
    scan_stopped_next      = scan_stopped;
    cap_we                 = 1'b0;
    finish                 = 1'b0;
    cap_idx                = byte_offset[CaptureIdxW-1:0] - CaptureIdxW'(1);
    off_inc                = byte_offset + ByteW'(1);
    if (in_fire && !scan_stopped) begin
      if (byte_offset == '0) begin
        descriptor_length_next = bytes.data_byte;
        if (bytes.data_byte < MinLength) begin
          scan_stopped_next = 1'b1;
        end else begin
          byte_offset_next = ByteW'(1);
        end
      end else begin
        cap_we = (byte_offset <= LastCaptureOff);
        if (off_inc >= descriptor_length) begin
          byte_offset_next = '0;
          finish           = 1'b1;
        end else begin
          byte_offset_next = off_inc;
        end
      end
    end
  end

  // Captured bytes with the byte of this cycle merged in.
  always_comb begin
    for (int i = 0; i < CaptureDepth; i++) begin
      view[i] = (cap_we && (cap_idx == CaptureIdxW'(i))) ? bytes.data_byte : capture_bytes[i];
    end
  end

  // Apply a finished descriptor to the group.
  assign in_as = group.flags[FlagAs] && (group.alt != '0);

  always_comb begin
    group_next = group;
    iface_stop = 1'b0;
    if (finish) begin
      if (view[0] == TypeIface && descriptor_length >= IfaceMinLen) begin
        if (setting_ok(group)) begin
          iface_stop = 1'b1;
        end else begin
          group_next        = '0;
          group_next.iface  = view[1];
          group_next.alt    = view[2];
          group_next.flags[FlagAs] = (view[4] == AudioClass) && (view[5] == AsSubclass);
        end
      end else if (view[0] == TypeClassIface && in_as && descriptor_length >= ClassMinLen) begin
        if (view[1] == SubGeneral && descriptor_length >= GeneralMinLen) begin
          group_next.flags[FlagPcm] = ({view[5], view[4]} == TagPcm);
        end else if (view[1] == SubFormat && descriptor_length >= FormatMinLen) begin
          group_next.flags[FlagFmt] = (view[2] == FmtTypeOne) && (view[6] != '0);
          group_next.channels       = view[3];
          group_next.subframe       = view[4];
          group_next.bits           = view[5];
          group_next.rate           = {view[9], view[8], view[7]};
        end
      end else if (view[0] == TypeEndpoint && in_as && descriptor_length >= EndpointMinLen) begin
        if (view[2][1:0] == XferIso && !view[1][ByteW-1]) begin
          group_next.endpoint = view[1];
          group_next.packet   = {view[4][PacketW-ByteW-1:0], view[3]};
        end
      end
    end
  end

  // Result word for the end of the set; fields are zero unless found.
  always_comb begin
    res_word = '0;
    if (setting_ok(group_next)) begin
      res_word.found            = 1'b1;
      res_word.iface_number     = group_next.iface;
      res_word.alt_setting      = group_next.alt;
      res_word.endpoint_address = group_next.endpoint;
      res_word.max_packet       = group_next.packet;
      res_word.channel_count    = group_next.channels;
      res_word.subframe_bytes   = group_next.subframe;
      res_word.resolution_bits  = group_next.bits;
      res_word.sample_rate      = group_next.rate;
    end
  end

  // Scan state registers; the end of the set returns them to reset.
  always_ff @(posedge clk) begin
    if (rst || res_fire) begin
      byte_offset       <= '0;
      descriptor_length <= '0;
      scan_stopped      <= 1'b0;
      group             <= '0;
    end else begin
      byte_offset       <= byte_offset_next;
      descriptor_length <= descriptor_length_next;
      scan_stopped      <= scan_stopped_next || iface_stop;
      group             <= group_next;
    end
  end

  // Capture store, written only inside the current descriptor.
  always_ff @(posedge clk) begin
    if (cap_we) begin
      capture_bytes[cap_idx] <= bytes.data_byte;
    end
  end

  // Output register and skid register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid && out_fire) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (res_fire && out_valid && !result.ready) begin
        skid_valid <= 1'b1;
      end else if (res_fire) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output and skid payload.
  always_ff @(posedge clk) begin
    if (skid_valid && out_fire) begin
      out_word <= skid_word;
    end else if (res_fire && out_valid && !result.ready) begin
      skid_word <= res_word;
    end else if (res_fire) begin
      out_word <= res_word;
    end
  end

  assign result.valid            = out_valid;
  assign result.found            = out_word.found;
  assign result.iface_number     = out_word.iface_number;
  assign result.alt_setting      = out_word.alt_setting;
  assign result.endpoint_address = out_word.endpoint_address;
  assign result.max_packet       = out_word.max_packet;
  assign result.channel_count    = out_word.channel_count;
  assign result.subframe_bytes   = out_word.subframe_bytes;
  assign result.resolution_bits  = out_word.resolution_bits;
  assign result.sample_rate      = out_word.sample_rate;

  // The skid register holds a word only behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  // The last byte of a set always leaves a result word waiting.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    res_fire |=> out_valid)
    else $error("no result word after the last byte of a set");

  // The last byte of a set returns the scan to its start.
  a_last_resets_scan: assert property (@(posedge clk) disable iff (rst)
    res_fire |=> (byte_offset == '0) && !scan_stopped && (group == '0))
    else $error("scan state not cleared after the last byte of a set");

  // A word without a found setting carries only zero fields.
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_word.found) |->
      (out_word.sample_rate == '0) && (out_word.endpoint_address == '0) &&
      (out_word.alt_setting == '0) && (out_word.max_packet == '0))
    else $error("result word without a setting carries nonzero fields");

endmodule

`default_nettype wire

// ----- bench/scan_checker.sv -----
// Checker: watches both channels, predicts each result word and compares it field by field.
`timescale 1ns / 1ps

module scan_checker import usbao_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  usbao_byte_if   bytes_mon,
  usbao_result_if result_mon,
  output int      fail_count,
  output int      pending,
  output int      checked,
  output int      found_seen
);

  // Endpoint address bit that marks an IN endpoint.
  localparam int DirInBit = 7;

  // Scan position and the bytes kept from the current descriptor.
  logic [ByteW-1:0]   offset;
  logic [ByteW-1:0]   cur_length;
  logic [ByteW-1:0]   cap [CaptureDepth];
  logic               stopped;

  // The group opened by the most recent interface descriptor.
  logic [ByteW-1:0]   g_iface;
  logic [ByteW-1:0]   g_alt;
  logic [FlagW-1:0]   g_flags;
  logic [ByteW-1:0]   g_ch;
  logic [ByteW-1:0]   g_sub;
  logic [ByteW-1:0]   g_bits;
  logic [RateW-1:0]   g_rate;
  logic [ByteW-1:0]   g_ep;
  logic [PacketW-1:0] g_pkt;

  // Result words predicted for finished sets, oldest first.
  result_t due_settings[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    found_seen = 0;
  end

  function automatic void clear_scan();
    offset     = '0;
    cur_length = '0;
    stopped    = 1'b0;
    g_iface    = '0;
    g_alt      = '0;
    g_flags    = '0;
    g_ch       = '0;
    g_sub      = '0;
    g_bits     = '0;
    g_rate     = '0;
    g_ep       = '0;
    g_pkt      = '0;
  endfunction

  function automatic logic setting_complete();
    return (&g_flags) && g_alt != 0 && g_ch != 0 && g_sub == WantSubframe &&
           g_bits == WantBits && g_rate != 0 && g_ep != 0;
  endfunction

  // Apply a descriptor once its last byte has been taken.
  function automatic void apply_descriptor();
    logic in_as;
    in_as = g_flags[FlagAs] && g_alt != 0;
    if (cap[0] == TypeIface && cur_length >= IfaceMinLen) begin
      if (setting_complete()) begin
        stopped = 1'b1;
      end else begin
        g_iface         = cap[1];
        g_alt           = cap[2];
        g_flags         = '0;
        g_flags[FlagAs] = cap[4] == AudioClass && cap[5] == AsSubclass;
        g_ch            = '0;
        g_sub           = '0;
        g_bits          = '0;
        g_rate          = '0;
        g_ep            = '0;
        g_pkt           = '0;
      end
    end else if (cap[0] == TypeClassIface && in_as && cur_length >= ClassMinLen) begin
      if (cap[1] == SubGeneral && cur_length >= GeneralMinLen) begin
        g_flags[FlagPcm] = {cap[5], cap[4]} == TagPcm;
      end else if (cap[1] == SubFormat && cur_length >= FormatMinLen) begin
        g_flags[FlagFmt] = cap[2] == FmtTypeOne && cap[6] >= 1;
        g_ch             = cap[3];
        g_sub            = cap[4];
        g_bits           = cap[5];
        g_rate           = {cap[9], cap[8], cap[7]};
      end
    end else if (cap[0] == TypeEndpoint && in_as && cur_length >= EndpointMinLen) begin
      if (cap[2][1:0] == XferIso && !cap[1][DirInBit]) begin
        g_ep  = cap[1];
        g_pkt = {cap[4][2:0], cap[3]};
      end
    end
  endfunction

  // Advance the scan by one byte; the final byte of a set yields a result word.
  function automatic void scan_byte(logic [ByteW-1:0] b, logic last);
    result_t r;
    if (!stopped) begin
      if (offset == 0) begin
        cur_length = b;
        if (b < MinLength) stopped = 1'b1;
        else offset = 8'd1;
      end else begin
        if (offset <= LastCaptureOff) cap[CaptureIdxW'(offset - 8'd1)] = b;
        offset = offset + 8'd1;
        if (offset >= cur_length) begin
          offset = '0;
          apply_descriptor();
        end
      end
    end
    if (last) begin
      r = '0;
      if (setting_complete()) begin
        r.found            = 1'b1;
        r.iface_number     = g_iface;
        r.alt_setting      = g_alt;
        r.endpoint_address = g_ep;
        r.max_packet       = g_pkt;
        r.channel_count    = g_ch;
        r.subframe_bytes   = g_sub;
        r.resolution_bits  = g_bits;
        r.sample_rate      = g_rate;
      end
      due_settings.push_back(r);
      clear_scan();
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Both channels are sampled at the clock edge where a word moves.
  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      clear_scan();
      due_settings.delete();
    end else begin
      if (result_mon.valid && result_mon.ready) begin
        if (due_settings.size() == 0) begin
          $error("result word arrived with no descriptor set pending");
          fail_count++;
        end else begin
          want = due_settings.pop_front();
          check_field("found", 32'(want.found), 32'(result_mon.found));
          check_field("iface_number", 32'(want.iface_number),
                      32'(result_mon.iface_number));
          check_field("alt_setting", 32'(want.alt_setting), 32'(result_mon.alt_setting));
          check_field("endpoint_address", 32'(want.endpoint_address),
                      32'(result_mon.endpoint_address));
          check_field("max_packet", 32'(want.max_packet), 32'(result_mon.max_packet));
          check_field("channel_count", 32'(want.channel_count),
                      32'(result_mon.channel_count));
          check_field("subframe_bytes", 32'(want.subframe_bytes),
                      32'(result_mon.subframe_bytes));
          check_field("resolution_bits", 32'(want.resolution_bits),
                      32'(result_mon.resolution_bits));
          check_field("sample_rate", 32'(want.sample_rate), 32'(result_mon.sample_rate));
          checked++;
          if (result_mon.found === 1'b1) found_seen++;
        end
      end
      if (bytes_mon.valid && bytes_mon.ready) begin
        scan_byte(bytes_mon.data_byte, bytes_mon.end_of_set);
      end
    end
    pending = due_settings.size();
  end

endmodule

// ----- bench/tb.sv -----
// Testbench top: clock, reset, descriptor set stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module tb;
  import usbao_pkg::*;

  localparam int HoldCycles = 300;
  localparam int ByteTarget = 1850;
  localparam int SetTarget  = 48;

  logic clk;
  logic rst = 1'b1;

  usbao_byte_if   byte_ch ();
  usbao_result_if res_ch ();

  int fail_count;
  int pending;
  int checked;
  int found_seen;

  usb_audio_out_descriptor_scanner u_top (
    .clk    (clk),
    .rst    (rst),
    .bytes  (byte_ch),
    .result (res_ch)
  );

  scan_checker u_monitor (
    .clk        (clk),
    .rst        (rst),
    .bytes_mon  (byte_ch),
    .result_mon (res_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .found_seen (found_seen)
  );

  // Bytes of the set being built, and a scratch copy of descriptor bytes 1 to 10.
  logic [ByteW-1:0] set_bytes[$];
  logic [ByteW-1:0] body[CaptureDepth];

  int bytes_sent;
  int sets_sent;
  bit no_gaps;
  bit hold_req;
  bit holding;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The run must end well before this, even with every stall at its longest.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic bit pct(int n);
    return $urandom_range(0, 99) < n;
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ByteW-1:0] mostly(logic [ByteW-1:0] want, int pct_off);
    return pct(pct_off) ? 8'($urandom) : want;
  endfunction

  function automatic void start_body();
    foreach (body[k]) body[k] = 8'($urandom);
  endfunction

  // Append a descriptor of the given length; bytes past the tenth are random.
  function automatic void emit(int len);
    int k;
    set_bytes.push_back(8'(len));
    for (k = 1; k < len; k++) set_bytes.push_back(k <= 10 ? body[k - 1] : 8'($urandom));
  endfunction

  function automatic void add_other();
    start_body();
    emit($urandom_range(2, 16));
  endfunction

  function automatic void add_iface(logic [ByteW-1:0] num, logic [ByteW-1:0] alt,
                                    bit streaming);
    int len;
    start_body();
    body[0] = TypeIface;
    body[1] = num;
    body[2] = alt;
    if (streaming) begin
      body[4] = mostly(AudioClass, 6);
      body[5] = mostly(AsSubclass, 6);
    end
    len = pct(90) ? 9 : (pct(50) ? 8 : $urandom_range(10, 14));
    emit(len);
  endfunction

  function automatic void add_general();
    start_body();
    body[0] = TypeClassIface;
    body[1] = SubGeneral;
    body[4] = mostly(TagPcm[7:0], 8);
    body[5] = mostly(TagPcm[15:8], 5);
    emit(pct(90) ? 7 : $urandom_range(5, 9));
  endfunction

  function automatic void add_format();
    int nfreq;
    logic [RateW-1:0] rate;
    start_body();
    case ($urandom_range(0, 5))
      0: rate = 24'd44100;
      1: rate = 24'd48000;
      2: rate = 24'd32000;
      3: rate = 24'd96000;
      4: rate = 24'($urandom);
      default: rate = pct(30) ? '0 : 24'd48000;
    endcase
    nfreq = pct(95) ? $urandom_range(1, 3) : 0;
    body[0] = TypeClassIface;
    body[1] = SubFormat;
    body[2] = mostly(FmtTypeOne, 5);
    body[3] = pct(93) ? 8'($urandom_range(1, 8)) : 8'($urandom);
    body[4] = mostly(WantSubframe, 8);
    body[5] = mostly(WantBits, 8);
    body[6] = 8'(nfreq);
    body[7] = rate[7:0];
    body[8] = rate[15:8];
    body[9] = rate[23:16];
    emit(pct(6) ? 10 : 8 + 3 * (nfreq == 0 ? 1 : nfreq));
  endfunction

  function automatic void add_endpoint();
    start_body();
    body[0] = TypeEndpoint;
    if (pct(90)) body[1][7] = 1'b0;
    if (pct(3)) body[1] = '0;
    if (pct(90)) body[2][1:0] = XferIso;
    emit(pct(92) ? (pct(50) ? 9 : 7) : 6);
  endfunction

  // One random descriptor set: mostly well-formed streaming groups, some noise.
  function automatic void build_set();
    int groups;
    set_bytes.delete();
    if (pct(8)) begin
      repeat ($urandom_range(1, 24)) set_bytes.push_back(8'($urandom));
      return;
    end
    if (pct(40)) add_other();
    if (pct(25)) begin
      add_iface(8'($urandom), '0, 1'b0);
      if (pct(50)) add_general();
      if (pct(30)) add_endpoint();
    end
    if (pct(25)) begin
      add_iface(8'($urandom), '0, 1'b1);
      if (pct(50)) add_format();
    end
    groups = pct(40) ? 2 : 1;
    repeat (groups) begin
      add_iface(8'($urandom), pct(95) ? 8'($urandom_range(1, 4)) : 8'h00, 1'b1);
      if (pct(20) && pct(92)) add_endpoint();
      if (pct(92)) add_general();
      if (pct(92)) add_format();
      if (pct(30)) add_other();
      if (pct(92)) add_endpoint();
    end
    if (pct(15)) add_other();
    // A length byte below the minimum stops the scan.
    if (pct(5)) begin
      set_bytes.push_back(8'($urandom_range(0, 1)));
      repeat ($urandom_range(0, 6)) set_bytes.push_back(8'($urandom));
    end
    // Cut the set short so that the last descriptor is unfinished.
    if (pct(15)) begin
      groups = $urandom_range(1, set_bytes.size());
      while (set_bytes.size() > groups) void'(set_bytes.pop_back());
    end
  endfunction

  task automatic send_word(logic [ByteW-1:0] b, logic last);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid      <= 1'b1;
    byte_ch.data_byte  <= b;
    byte_ch.end_of_set <= last;
    do @(posedge clk); while (byte_ch.ready !== 1'b1);
    bytes_sent++;
  endtask

  task automatic send_set();
    foreach (set_bytes[i]) send_word(set_bytes[i], i == set_bytes.size() - 1);
    sets_sent++;
  endtask

  // Result side: random stalls and runs, plus one long hold-off on request.
  initial begin : receiver
    int stall_left;
    int run_left;
    int hold_left;
    stall_left = 0;
    run_left   = 0;
    hold_left  = 0;
    res_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !holding) begin
        holding   = 1'b1;
        hold_left = HoldCycles;
      end
      if (holding) begin
        res_ch.ready <= 1'b0;
        hold_left--;
        if (hold_left == 0) begin
          holding  = 1'b0;
          hold_req = 1'b0;
        end
      end else begin
        if (stall_left == 0 && run_left == 0) begin
          stall_left = pick_gap();
          run_left   = pct(10) ? $urandom_range(100, 300) : $urandom_range(1, 30);
        end
        if (stall_left > 0) begin
          res_ch.ready <= 1'b0;
          stall_left--;
        end else begin
          res_ch.ready <= 1'b1;
          run_left--;
        end
      end
      @(posedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    bytes_sent = 0;
    sets_sent  = 0;
    no_gaps    = 1'b0;
    hold_req   = 1'b0;
    holding    = 1'b0;
    byte_ch.valid      <= 1'b0;
    byte_ch.data_byte  <= '0;
    byte_ch.end_of_set <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero length, a lone length byte, a stopped scan with data after
    // it, a two-byte descriptor before a cut-off interface, and descriptors too
    // short to have any effect.
    set_bytes = '{8'h00};
    send_set();
    set_bytes = '{8'hFF};
    send_set();
    set_bytes = '{8'h01, 8'hFF, 8'h00};
    send_set();
    set_bytes = '{8'h02, TypeIface, 8'h09, TypeIface, 8'h00, 8'h01};
    send_set();
    set_bytes = '{8'h03, TypeClassIface, SubFormat,
                  8'h06, TypeEndpoint, 8'h01, 8'h01, 8'hFF, 8'hFF};
    send_set();

    // Back-pressure: the result side holds off while one-word sets keep coming.
    hold_req = 1'b1;
    byte_ch.valid <= 1'b0;
    wait (holding);
    no_gaps = 1'b1;
    repeat (24) begin
      set_bytes = '{8'($urandom)};
      send_set();
    end

    // Random descriptor sets.
    while (bytes_sent < ByteTarget || sets_sent < SetTarget) begin
      build_set();
      no_gaps = pct(20);
      send_set();
    end
    byte_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d descriptor sets in %0d bytes.", sets_sent, bytes_sent);
    $display("Checked %0d result words, %0d of them with a streaming setting found.",
             checked, found_seen);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
